/* src/faa_pkg.sv */
// Package: shared constants, the queued item type and BCD helpers for the autorange ASCII unit.
`timescale 1ns / 1ps
package faa_pkg;

    localparam int MAX_DIGITS  = 8;
    localparam int VALUE_W     = 32;
    localparam int MAG_W       = VALUE_W - 1;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int CNT_W       = $clog2(MAG_W);
    localparam int DCNT_W      = 4;
    localparam int CHAR_W      = 6;

    localparam logic [DCNT_W-1:0] DIGIT_COUNT_RESET = 4'd4;
    localparam logic [DCNT_W-1:0] DIGITS_MAX        = DCNT_W'(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CH_POINT = 6'd46;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

    // Integer part starts at BCD digit 2 (value is in hundredths).
    localparam int INT_LSD = 2;

    typedef struct packed {
        logic              neg;
        logic [BCD_W-1:0]  bcd;
        logic [DCNT_W-1:0] n;
        logic [DCNT_W-1:0] d;
    } t_item;

    function automatic logic [3:0] bcd_digit(input logic [BCD_W-1:0] bcd,
                                             input logic [3:0] idx);
        logic [3:0] f;
        f = bcd[4*idx +: 4];
        return f;
    endfunction

endpackage

/* src/faa_front.sv */
// Front end: accept a value, convert its magnitude to BCD bit-serially, classify point position.
`timescale 1ns / 1ps
module faa_front import faa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [DCNT_W-1:0]   i_digit_count,
    output logic                o_item_valid,
    output t_item               o_item,
    input  logic                i_item_full
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MAG_W-1:0]  r_bin, n_bin;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic              r_neg, n_neg;
    logic [DCNT_W-1:0] r_n, n_n;

    logic [VALUE_W-1:0] neg_value;
    logic [MAG_W-1:0]   mag;
    logic [BCD_W-1:0]   bcd_adj;
    logic [DCNT_W-1:0]  hi, digs, d;

    assign neg_value = VALUE_W'(0) - i_value;

    always_comb begin
        if (!i_value[VALUE_W-1]) begin
            mag = i_value[MAG_W-1:0];
        end else if (neg_value[VALUE_W-1]) begin
            mag = {MAG_W{1'b1}};    // most negative value saturates
        end else begin
            mag = neg_value[MAG_W-1:0];
        end
    end

    // Double dabble correction: add 3 to every digit of 5 or more.
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                bcd_adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                bcd_adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    // Count integer digits and place the point.
    always_comb begin
        hi = '0;
        for (int k = INT_LSD; k < BCD_DIGITS; k++) begin
            if (bcd_digit(r_bcd, 4'(k)) != 4'd0) begin
                hi = DCNT_W'(k);
            end
        end
        digs = (hi == '0) ? '0 : hi - DCNT_W'(INT_LSD - 1);
        if (digs >= r_n) begin
            d = '0;
        end else if (digs == '0) begin
            d = r_n - 4'd1;
        end else begin
            d = r_n - digs;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        n_n     = r_n;
        case (r_state)
            S_IDLE: begin
                if (i_push) begin
                    n_bin   = mag;
                    n_bcd   = '0;
                    n_neg   = i_value[VALUE_W-1];
                    n_cnt   = CNT_W'(MAG_W - 1);
                    if (i_digit_count == '0) begin
                        n_n = 4'd1;
                    end else if (i_digit_count > DIGITS_MAX) begin
                        n_n = DIGITS_MAX;
                    end else begin
                        n_n = i_digit_count;
                    end
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[MAG_W-1]};
                n_bin = {r_bin[MAG_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_item_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
        r_n   <= n_n;
    end

    assign o_full       = (r_state != S_IDLE);
    assign o_item_valid = (r_state == S_DONE) && !i_item_full;
    assign o_item.neg   = r_neg;
    assign o_item.bcd   = r_bcd;
    assign o_item.n     = r_n;
    assign o_item.d     = d;

endmodule

/* src/faa_fifo.sv */
// Two-entry item queue between the front end and the character emitter.
`timescale 1ns / 1ps
module faa_fifo import faa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_data,
    output logic  o_empty
);

    t_item      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

/* src/faa_back.sv */
// Back end: walk a queued item, emitting sign, digits, point and padding, one char a cycle while output is free.
`timescale 1ns / 1ps
module faa_back import faa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_empty,
    input  t_item             i_item,
    output logic              o_item_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_last_char
);

    t_item             r_item;
    logic              r_busy;
    logic [DCNT_W-1:0] r_k, r_wr;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_last, n_last;
    logic              out_free, emit, is_digit;
    logic signed [5:0] e;
    logic [3:0]        dig;

    assign out_free   = !r_out_valid || i_pop;
    assign emit       = r_busy && out_free;
    assign o_item_pop = !r_busy && !i_item_empty;

    assign e = $signed({2'b00, r_item.n}) + 6'sd1
             - $signed({2'b00, r_item.d}) - $signed({2'b00, r_wr});
    assign dig = (e < 6'sd0) ? 4'd0 : bcd_digit(r_item.bcd, e[3:0]);

    always_comb begin
        is_digit = 1'b0;
        if (r_k == '0) begin
            n_char = r_item.neg ? CH_MINUS : CH_SPACE;
        end else if (r_item.d == 4'd1 && r_k == 4'd1) begin
            n_char = CH_SPACE;
        end else if (r_item.d != 4'd1 && (r_k - 4'd1) == (r_item.n - r_item.d)) begin
            n_char = CH_POINT;
        end else begin
            n_char   = CH_ZERO + CHAR_W'(dig);
            is_digit = 1'b1;
        end
        n_last = (r_k == r_item.n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_pop) begin
                r_busy <= 1'b1;
            end else if (emit && n_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_item_pop) begin
            r_item <= i_item;
            r_k    <= '0;
            r_wr   <= '0;
        end else if (emit) begin
            r_k <= r_k + 4'd1;
            if (is_digit) begin
                r_wr <= r_wr + 4'd1;
            end
        end
        if (emit) begin
            r_char <= n_char;
            r_last <= n_last;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

/* src/fixed_point_to_autorange_ascii_unit.sv */
// Top level: fixed-point hundredths to auto-ranging ASCII field converter.
// Each input passes the BCD conversion, the item queue and the output register.
// The front takes the next input only after its 31-step bit-serial BCD conversion and hand-off;
// the emitter then gives clamped digit_count+1 characters, one per cycle while pop stays high.
// Reset (synchronous, active low): digit_count returns to 4, queues and output register empty.
`timescale 1ns / 1ps
module fixed_point_to_autorange_ascii_unit import faa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item queue side
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] i_value,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output logic [CHAR_W-1:0]  o_character,
    output logic               o_last_char,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [DCNT_W-1:0]  i_cfg_data
);

    logic [DCNT_W-1:0] r_digit_count;

    t_item q_in, q_out;
    logic  q_push, q_full, q_pop, q_empty;

    // Configuration is to arrive only while idle; the block does not enforce this and always accepts it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= DIGIT_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_digit_count <= i_cfg_data;
        end
    end

    // Front end: take the transfer, latch the clamped digit count, convert to BCD,
    // then decide the point position from the count of integer digits.
    faa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_value       (i_value),
        .i_digit_count (r_digit_count),
        .o_item_valid  (q_push),
        .o_item        (q_in),
        .i_item_full   (q_full)
    );

    // Short queue: lets the front convert the next value while the back still emits.
    faa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Back end: sequence the field characters into a registered output stage.
    faa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_empty (q_empty),
        .i_item       (q_out),
        .o_item_pop   (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_character  (o_character),
        .o_last_char  (o_last_char)
    );

endmodule

/* tb/ascii_field_monitor.sv */
// Watches the value and character channels, predicts each ASCII field and compares it.
`timescale 1ns / 1ps
module ascii_field_monitor import faa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [CHAR_W-1:0]  i_character,
    input  logic               i_last_char,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [DCNT_W-1:0]  i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } t_ascii_char;

    t_ascii_char       expected_chars[$];
    logic [DCNT_W-1:0] digit_count = DIGIT_COUNT_RESET;
    int                char_index  = 0;
    int                fail_count  = 0;

    // Decimal digit of mag at power e of ten; powers outside 0..10 give zero.
    function automatic longint unsigned decimal_digit(input longint unsigned mag, input int e);
        longint unsigned scale;
        scale = 1;
        if (e < 0 || e > 10) return 0;
        for (int i = 0; i < e; i++) scale = scale * 10;
        return (mag / scale) % 10;
    endfunction

    // Queue the sign character and the clamped digit_count characters of one field.
    function automatic void queue_field(input logic [VALUE_W-1:0] value,
                                        input logic [DCNT_W-1:0] count);
        logic            neg;
        longint unsigned mag;
        longint unsigned ip;
        int              n;
        int              d;
        int              digs;
        int              pos;
        int              written;
        t_ascii_char     c;
        neg = value[VALUE_W-1];
        mag = {32'd0, value};
        if (neg) begin
            mag = ((~mag) + 1) & 64'hFFFF_FFFF;
            if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        end
        n = count;
        if (n < 1) n = 1;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        ip   = mag / 100;
        digs = 0;
        while (ip != 0) begin
            digs++;
            ip = ip / 10;
        end
        d = n - digs;
        if (d < 0) d = 0;
        if (d > n - 1) d = n - 1;

        c.character = neg ? CH_MINUS : CH_SPACE;
        c.last_char = 1'b0;
        expected_chars.push_back(c);
        pos     = 0;
        written = 0;
        // one decimal place: a leading blank stands where the point would go
        if (d == 1) begin
            c.character = CH_SPACE;
            expected_chars.push_back(c);
            pos++;
        end
        while (pos < n) begin
            if (pos == n - d && d != 1) begin
                c.character = CH_POINT;
            end else begin
                c.character = CH_ZERO + CHAR_W'(decimal_digit(mag, n + 1 - d - written));
                written++;
            end
            expected_chars.push_back(c);
            pos++;
        end
        c = expected_chars.pop_back();
        c.last_char = 1'b1;
        expected_chars.push_back(c);
    endfunction

    always @(posedge i_clk) begin : monitor_proc
        t_ascii_char head;
        if (!i_rst_n) begin
            digit_count = DIGIT_COUNT_RESET;
        end else begin
            if (i_push && !i_full) queue_field(i_value, digit_count);
            if (i_cfg_valid && i_cfg_ready) digit_count = i_cfg_data;
            if (i_pop && !i_empty) begin
                if (expected_chars.size() == 0) begin
                    if (fail_count < 10)
                        $display("character %0d arrived with none pending: char 0x%02h last %0b",
                                 char_index, i_character, i_last_char);
                    fail_count++;
                end else begin
                    head = expected_chars.pop_front();
                    if (head.character !== i_character || head.last_char !== i_last_char) begin
                        if (fail_count < 10)
                            $display({"character %0d mismatch: expected char 0x%02h last %0b, ",
                                      "got char 0x%02h last %0b"}, char_index, head.character,
                                     head.last_char, i_character, i_last_char);
                        fail_count++;
                    end
                end
                char_index++;
            end
        end
        o_pending    = expected_chars.size();
        o_fail_count = fail_count;
    end

endmodule

/* tb/fixed_point_to_autorange_ascii_unit_tb.sv */
// Stimulus and verdict for the fixed-point to auto-ranging ASCII unit.
`timescale 1ns / 1ps
module fixed_point_to_autorange_ascii_unit_tb;
    import faa_pkg::*;

    localparam int RX_STALL_CYCLES = 1500;
    localparam int DRAIN_CYCLES    = 60;
    localparam int PHASE_ITEMS     = 19;
    localparam int STALL_ITEMS     = 40;
    localparam int STALL_PHASE     = 4;
    localparam int BURST_PHASE     = 6;

    // All inputs start at known values; reset is held low from time zero.
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic [VALUE_W-1:0] i_value     = '0;
    logic               pop         = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [DCNT_W-1:0]  i_cfg_data  = '0;
    logic               full;
    logic               empty;
    logic [CHAR_W-1:0]  o_character;
    logic               o_last_char;
    logic               o_cfg_ready;

    int   fail_count;
    int   pending;
    logic tx_no_idle   = 1'b0;
    logic rx_stall_req = 1'b0;

    // Directed values at the reset digit count: zero, signs, decimal boundaries and the
    // saturation corner; the largest magnitude overflows four characters.
    logic [VALUE_W-1:0] directed_values [14] = '{
        0, 1, -1, 99, 100, -100, 999, 1000, 12345, -12345, 99999,
        32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000
    };

    // Digit counts per phase; zero and fifteen exercise the clamping and every bit.
    logic [DCNT_W-1:0] phase_counts [10] = '{8, 0, 15, 3, 5, 6, 7, 2, 9, 1};

    fixed_point_to_autorange_ascii_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_value     (i_value),
        .empty       (empty),
        .pop         (pop),
        .o_character (o_character),
        .o_last_char (o_last_char),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    ascii_field_monitor field_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_value      (i_value),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_character  (o_character),
        .i_last_char  (o_last_char),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(12, 45);
    endfunction

    // Draw a value: full random words, the extremes, or a magnitude of a random number
    // of decimal digits (often right at a power of ten) with a random sign.
    function automatic logic [VALUE_W-1:0] random_value();
        int              pick;
        int              k;
        longint unsigned scale;
        longint unsigned mag;
        pick = $urandom_range(0, 9);
        if (pick == 0) return $urandom;
        if (pick == 1) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0001;
                default: return 0;
            endcase
        end
        k     = $urandom_range(0, 10);
        scale = 1;
        for (int i = 0; i < k; i++) scale = scale * 10;
        if (pick == 2 && scale > 1)
            mag = scale - $urandom_range(0, 1);
        else
            mag = {$urandom, $urandom} % scale;
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        if ($urandom_range(0, 1) == 1) mag = (~mag) + 1;
        return mag[VALUE_W-1:0];
    endfunction

    // Offer one value and hold it until the transfer; return on the next falling edge
    // with push still high, so a back-to-back value simply replaces it.
    task automatic push_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = tx_no_idle ? 0 : idle_gap();
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push    = 1'b1;
        i_value = value;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    // Drop push, wait until every character of the queued fields has been taken,
    // then write the digit count over the configuration channel.
    task automatic set_digit_count(input logic [DCNT_W-1:0] count);
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = count;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Receiver: pop with random gaps, runs of back-to-back pops, and one long hold-off
    // on request, counted here so the sender keeps offering meanwhile.
    initial begin : receiver
        int gap;
        int burst_left;
        burst_left = 0;
        wait (i_rst_n);
        forever begin
            if (rx_stall_req) begin
                rx_stall_req = 1'b0;
                pop = 1'b0;
                repeat (RX_STALL_CYCLES) @(negedge i_clk);
            end
            if (burst_left > 0) begin
                gap = 0;
                burst_left--;
            end else begin
                gap = idle_gap();
                if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(20, 60);
            end
            if (gap > 0) begin
                pop = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            @(negedge i_clk);
        end
    end

    // Sender and verdict.
    initial begin : sender
        int items;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the reset digit count of four
        foreach (directed_values[i]) push_value(directed_values[i]);

        // one character: only integer digits, a bare zero for small values
        set_digit_count(1);
        push_value(0);
        push_value(12345);
        push_value(-7);

        // two characters: a blank in place of the point for a zero integer part
        set_digit_count(2);
        push_value(50);
        push_value(-999);

        // widest field, up to the saturated most negative value
        set_digit_count(8);
        push_value(0);
        push_value(-123456789);
        push_value(32'h7FFF_FFFF);
        push_value(32'h8000_0000);

        // random phases, each at its own digit count
        foreach (phase_counts[p]) begin
            set_digit_count(phase_counts[p]);
            items = PHASE_ITEMS;
            if (p == STALL_PHASE) begin
                // hold the receiver off while values keep coming, to fill the unit
                items        = STALL_ITEMS;
                tx_no_idle   = 1'b1;
                rx_stall_req = 1'b1;
            end
            if (p == BURST_PHASE) tx_no_idle = 1'b1;
            repeat (items) push_value(random_value());
            tx_no_idle = 1'b0;
        end

        // drain: nothing left pending, then a few more cycles for stray characters
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hang anywhere in the run.
    initial begin : watchdog
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
